// ----- design/ssd_pkg.sv -----
// Shared types, widths and latency constants for the segment distance core.
`timescale 1ns / 1ps

package ssd_pkg;

    localparam int FIELD_W     = 16;
    localparam int COORD_WIDTH = 16;
    localparam int FRAC_BITS   = 16;

    // coordinate width actually used
    localparam int CW = (COORD_WIDTH < FIELD_W) ? COORD_WIDTH : FIELD_W;
    localparam int DW = CW + 1;            // coordinate difference
    localparam int PW = 2 * DW;            // product of two differences
    localparam int SW = PW + 1;            // sum of two products
    localparam int LW = 2 * CW + 1;        // squared length, |cross|
    localparam int VW = 2 * LW;            // squared cross product
    localparam int QW = LW + 2 * FRAC_BITS; // scaled squared distance
    localparam int RB = (QW + 1) / 2;      // root width

    localparam int OUT_W = 34;
    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

    localparam int LEG_LAT   = 5;
    localparam int MIN_LAT   = 2;
    localparam int MEET_LAT  = QW + MIN_LAT + RB;
    localparam int TOTAL_LAT = LEG_LAT + QW + MIN_LAT + RB + 1;

    typedef struct packed {
        logic signed [FIELD_W-1:0] first_start_x;
        logic signed [FIELD_W-1:0] first_start_y;
        logic signed [FIELD_W-1:0] first_end_x;
        logic signed [FIELD_W-1:0] first_end_y;
        logic signed [FIELD_W-1:0] second_start_x;
        logic signed [FIELD_W-1:0] second_start_y;
        logic signed [FIELD_W-1:0] second_end_x;
        logic signed [FIELD_W-1:0] second_end_y;
    } seg_item_t;

    typedef struct packed {
        logic [OUT_W-1:0] distance_fixed;
        logic             segments_meet;
    } seg_result_t;

    // orientation of a point against a ray: zero, or the sign of the code
    typedef struct packed {
        logic zero;
        logic neg;
    } ori_t;

    typedef struct packed {
        ori_t            ori;
        logic [VW-1:0]   value;
        logic [LW-1:0]   den;
    } leg_out_t;

endpackage

// ----- design/ssd_leg.sv -----
// Front end: orientation test and point-to-segment numerator/denominator, five stages.
`timescale 1ns / 1ps

module ssd_leg
    import ssd_pkg::*;
(
    input  logic                 clk,
    input  logic signed [CW-1:0] a_x,
    input  logic signed [CW-1:0] a_y,
    input  logic signed [CW-1:0] b_x,
    input  logic signed [CW-1:0] b_y,
    input  logic signed [CW-1:0] p_x,
    input  logic signed [CW-1:0] p_y,
    output leg_out_t             leg
);

    // stage 1: differences
    logic signed [DW-1:0] ux_reg, uy_reg, vx_reg, vy_reg, wx_reg, wy_reg;

    always_ff @(posedge clk)
    begin
        ux_reg <= DW'(b_x) - DW'(a_x);
        uy_reg <= DW'(b_y) - DW'(a_y);
        vx_reg <= DW'(p_x) - DW'(a_x);
        vy_reg <= DW'(p_y) - DW'(a_y);
        wx_reg <= DW'(p_x) - DW'(b_x);
        wy_reg <= DW'(p_y) - DW'(b_y);
    end

    // stage 2: products
    logic signed [PW-1:0] uxvx_reg, uyvy_reg, uxwx_reg, uywy_reg;
    logic signed [PW-1:0] uxvy_reg, uyvx_reg, uxwy_reg, uywx_reg;
    logic signed [PW-1:0] uxux_reg, uyuy_reg, vxvx_reg, vyvy_reg, wxwx_reg, wywy_reg;

    always_ff @(posedge clk)
    begin
        uxvx_reg <= ux_reg * vx_reg;
        uyvy_reg <= uy_reg * vy_reg;
        uxwx_reg <= ux_reg * wx_reg;
        uywy_reg <= uy_reg * wy_reg;
        uxvy_reg <= ux_reg * vy_reg;
        uyvx_reg <= uy_reg * vx_reg;
        uxwy_reg <= ux_reg * wy_reg;
        uywx_reg <= uy_reg * wx_reg;
        uxux_reg <= ux_reg * ux_reg;
        uyuy_reg <= uy_reg * uy_reg;
        vxvx_reg <= vx_reg * vx_reg;
        vyvy_reg <= vy_reg * vy_reg;
        wxwx_reg <= wx_reg * wx_reg;
        wywy_reg <= wy_reg * wy_reg;
    end

    // stage 3: sums
    logic signed [SW-1:0] dotv_reg, dotw_reg, cr_reg, im_reg;
    logic [LW-1:0]        len2_reg, dv2_reg, dw2_reg;
    logic signed [SW-1:0] len2_next, dv2_next, dw2_next;

    always_comb
    begin
        len2_next = SW'(uxux_reg) + SW'(uyuy_reg);
        dv2_next  = SW'(vxvx_reg) + SW'(vyvy_reg);
        dw2_next  = SW'(wxwx_reg) + SW'(wywy_reg);
    end

    always_ff @(posedge clk)
    begin
        dotv_reg <= SW'(uxvx_reg) + SW'(uyvy_reg);
        dotw_reg <= SW'(uxwx_reg) + SW'(uywy_reg);
        cr_reg   <= SW'(uxvy_reg) - SW'(uyvx_reg);
        im_reg   <= SW'(uxwy_reg) - SW'(uywx_reg);
        len2_reg <= len2_next[LW-1:0];
        dv2_reg  <= dv2_next[LW-1:0];
        dw2_reg  <= dw2_next[LW-1:0];
    end

    // stage 4: orientation code and case selection
    ori_t                 ori_next, ori4_reg, ori5_reg;
    logic                 perp_next, perp_reg;
    logic [LW-1:0]        d2_next, d2_reg, den_next, den4_reg, den5_reg, mag_reg;
    logic signed [SW-1:0] abs_cr;
    logic [VW-1:0]        value_next, value_reg;

    always_comb
    begin
        // ray from b back through a, point p: im and re use the u, w terms
        if (im_reg != '0)
        begin
            ori_next.zero = 1'b0;
            ori_next.neg  = im_reg[SW-1];
        end
        else if (dotw_reg > 0)
        begin
            ori_next.zero = 1'b0;   // behind the ray origin
            ori_next.neg  = 1'b0;
        end
        else if (len2_reg < dw2_reg)
        begin
            ori_next.zero = 1'b0;   // past the far end
            ori_next.neg  = 1'b1;
        end
        else
        begin
            ori_next.zero = 1'b1;
            ori_next.neg  = 1'b0;
        end

        perp_next = 1'b0;
        den_next  = LW'(1);
        if (len2_reg == '0)
            d2_next = dv2_reg;
        else if (dotv_reg[SW-1])
            d2_next = dv2_reg;
        else if (dotw_reg > 0)
            d2_next = dw2_reg;
        else
        begin
            d2_next   = dv2_reg;
            perp_next = 1'b1;
            den_next  = len2_reg;
        end

        abs_cr = cr_reg[SW-1] ? -cr_reg : cr_reg;
    end

    always_ff @(posedge clk)
    begin
        ori4_reg <= ori_next;
        perp_reg <= perp_next;
        d2_reg   <= d2_next;
        den4_reg <= den_next;
        mag_reg  <= abs_cr[LW-1:0];
    end

    // stage 5: numerator
    always_comb
    begin
        value_next = perp_reg ? VW'(mag_reg) * VW'(mag_reg) : VW'(d2_reg);
    end

    always_ff @(posedge clk)
    begin
        ori5_reg  <= ori4_reg;
        den5_reg  <= den4_reg;
        value_reg <= value_next;
    end

    assign leg.ori   = ori5_reg;
    assign leg.value = value_reg;
    assign leg.den   = den5_reg;

endmodule

// ----- design/ssd_div.sv -----
// Pipelined restoring divider: floor(value * 4^FRAC_BITS / den), one quotient bit per stage.
`timescale 1ns / 1ps

module ssd_div
    import ssd_pkg::*;
(
    input  logic          clk,
    input  logic [VW-1:0] value,
    input  logic [LW-1:0] den,
    output logic [QW-1:0] quot
);

    logic [LW-1:0] rem_reg [QW];
    logic [QW-1:0] nq_reg  [QW];
    logic [LW-1:0] den_reg [QW-1];

    for (genvar k = 0; k < QW; k++)
    begin : g_step
        logic [LW-1:0] rem_in, den_in, rem_next;
        logic [QW-1:0] nq_in, nq_next;
        logic [LW:0]   trial;
        logic          take;

        if (k == 0)
        begin : g_first
            // high part starts as remainder; low part then the scale zeros shift in
            assign rem_in = value[VW-1 -: LW];
            assign nq_in  = QW'(value[VW-LW-1:0]) << (2 * FRAC_BITS);
            assign den_in = den;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign nq_in  = nq_reg[k-1];
            assign den_in = den_reg[k-1];
        end

        always_comb
        begin
            trial    = {rem_in, nq_in[QW-1]};
            take     = trial >= {1'b0, den_in};
            rem_next = take ? LW'(trial - {1'b0, den_in}) : trial[LW-1:0];
            nq_next  = {nq_in[QW-2:0], take};
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= rem_next;
            nq_reg[k]  <= nq_next;
        end

        if (k < QW - 1)
        begin : g_den
            always_ff @(posedge clk)
            begin
                den_reg[k] <= den_in;
            end
        end
    end

    assign quot = nq_reg[QW-1];

endmodule

// ----- design/ssd_sqrt.sv -----
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps

module ssd_sqrt
    import ssd_pkg::*;
(
    input  logic          clk,
    input  logic [QW-1:0] radicand,
    output logic [RB-1:0] root
);

    logic [RB+1:0]   rem_reg  [RB];
    logic [RB-1:0]   root_reg [RB];
    logic [2*RB-1:0] qs_reg   [RB-1];

    for (genvar k = 0; k < RB; k++)
    begin : g_step
        logic [RB+1:0]   rem_in, rem_next;
        logic [RB-1:0]   root_in, root_next;
        logic [2*RB-1:0] qs_in;
        logic [RB+3:0]   trial, sub;
        logic            take;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign qs_in   = (2*RB)'(radicand);
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign qs_in   = qs_reg[k-1];
        end

        always_comb
        begin
            trial     = {rem_in, qs_in[2*RB-1 -: 2]};
            sub       = (RB+4)'({root_in, 2'b01});
            take      = trial >= sub;
            rem_next  = take ? (RB+2)'(trial - sub) : trial[RB+1:0];
            root_next = {root_in[RB-2:0], take};
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= rem_next;
            root_reg[k] <= root_next;
        end

        if (k < RB - 1)
        begin : g_qs
            always_ff @(posedge clk)
            begin
                qs_reg[k] <= qs_in << 2;
            end
        end
    end

    assign root = root_reg[RB-1];

endmodule

// ----- design/segment_to_segment_distance_core.sv -----
// Top level: distance between two 2D segments, fully pipelined.
`timescale 1ns / 1ps

// Takes one segment pair per clock whenever start is high; busy is always low,
// so every start beat is accepted. Each result appears on result for one cycle
// with result_valid high, in input order, once its start beat has passed the leg
// stages, the divider, the minimum stages, the square root and the output register.
// The divider resolves one quotient bit per stage (QW = 65 stages), and the square
// root one root bit per stage (RB = 33 stages). The receiver cannot stall the
// block; results must be taken when shown.

module segment_to_segment_distance_core
    import ssd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  seg_item_t   item,
    output logic        result_valid,
    output seg_result_t result
);

    logic signed [CW-1:0] ax, ay, bx, by, cx, cy, dx, dy;

    assign ax = item.first_start_x[CW-1:0];
    assign ay = item.first_start_y[CW-1:0];
    assign bx = item.first_end_x[CW-1:0];
    assign by = item.first_end_y[CW-1:0];
    assign cx = item.second_start_x[CW-1:0];
    assign cy = item.second_start_y[CW-1:0];
    assign dx = item.second_end_x[CW-1:0];
    assign dy = item.second_end_y[CW-1:0];

    assign busy = 1'b0;

    leg_out_t      leg [4];
    logic [QW-1:0] quot [4];

    ssd_leg u_leg0 (.clk, .a_x(ax), .a_y(ay), .b_x(bx), .b_y(by), .p_x(cx), .p_y(cy),
                    .leg(leg[0]));
    ssd_leg u_leg1 (.clk, .a_x(ax), .a_y(ay), .b_x(bx), .b_y(by), .p_x(dx), .p_y(dy),
                    .leg(leg[1]));
    ssd_leg u_leg2 (.clk, .a_x(cx), .a_y(cy), .b_x(dx), .b_y(dy), .p_x(ax), .p_y(ay),
                    .leg(leg[2]));
    ssd_leg u_leg3 (.clk, .a_x(cx), .a_y(cy), .b_x(dx), .b_y(dy), .p_x(bx), .p_y(by),
                    .leg(leg[3]));

    for (genvar i = 0; i < 4; i++)
    begin : g_div
        ssd_div u_div (.clk, .value(leg[i].value), .den(leg[i].den), .quot(quot[i]));
    end

    // product of two orientation codes is <= 0
    function automatic logic pair_ok(input ori_t o1, input ori_t o2);
        return o1.zero || o2.zero || (o1.neg != o2.neg);
    endfunction

    logic meet_now;
    assign meet_now = pair_ok(leg[0].ori, leg[1].ori) && pair_ok(leg[2].ori, leg[3].ori);

    logic meet_reg [MEET_LAT];

    always_ff @(posedge clk)
    begin
        meet_reg[0] <= meet_now;
        for (int j = 1; j < MEET_LAT; j++)
        begin
            meet_reg[j] <= meet_reg[j-1];
        end
    end

    // min over the four scaled squared distances; root is monotone
    logic [QW-1:0] min01_reg, min23_reg, min_reg;

    always_ff @(posedge clk)
    begin
        min01_reg <= (quot[1] < quot[0]) ? quot[1] : quot[0];
        min23_reg <= (quot[3] < quot[2]) ? quot[3] : quot[2];
        min_reg   <= (min23_reg < min01_reg) ? min23_reg : min01_reg;
    end

    logic [RB-1:0] root;

    ssd_sqrt u_sqrt (.clk, .radicand(min_reg), .root(root));

    logic [63:0]      root_wide;
    logic [OUT_W-1:0] dist_next;
    seg_result_t      result_reg;
    logic [TOTAL_LAT-1:0] valid_reg;

    always_comb
    begin
        root_wide = 64'(root);
        dist_next = (root_wide > 64'(OUT_MAX)) ? OUT_MAX : root_wide[OUT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        result_reg.segments_meet  <= meet_reg[MEET_LAT-1];
        result_reg.distance_fixed <= meet_reg[MEET_LAT-1] ? '0 : dist_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[TOTAL_LAT-2:0], start};
    end

    assign result_valid = valid_reg[TOTAL_LAT-1];
    assign result       = result_reg;

endmodule

// ----- design/ssd_checker.sv -----
// Port-level checker for the segment distance core, bound to the top level.
`timescale 1ns / 1ps

module ssd_checker
    import ssd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        result_valid,
    input seg_result_t result
);

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_meet_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.segments_meet |-> result.distance_fixed == '0)
        else $error("meeting segments with nonzero distance");

    a_beat_out: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##TOTAL_LAT result_valid)
        else $error("start beat lost");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start, TOTAL_LAT))
        else $error("result without start beat");

endmodule

bind segment_to_segment_distance_core ssd_checker u_ssd_checker (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .result_valid(result_valid),
    .result(result)
);

// ----- dv/segment_to_segment_distance_core_tb.sv -----
// Self-checking testbench for the segment_to_segment_distance_core block.
`timescale 1ns / 1ps

module segment_to_segment_distance_core_tb;
    import ssd_pkg::*;

    localparam int N_RANDOM    = 1200;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        seg_item_t   pair;
        bit          typed;
        seg_result_t want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    seg_item_t   item;
    logic        result_valid;
    seg_result_t result;

    seg_result_t pending_dist[$];
    int          n_errors;
    int          n_sent;
    int          n_checked;
    int          n_meet;
    int          cycle_count;
    bit          burst_mode;

    segment_to_segment_distance_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $time, what);
        n_errors++;
    endtask

    // largest r below 2^42 with r*r*den <= num, clipped to the output range
    function automatic logic [127:0] fixed_root(logic [127:0] num, logic [127:0] den);
        logic [127:0] r;
        logic [127:0] t;
        r = '0;
        for (int b = 41; b >= 0; b--)
        begin
            t = r | (128'd1 << b);
            if (t * t * den <= num)
                r = t;
        end
        if (r > 128'(OUT_MAX))
            r = 128'(OUT_MAX);
        return r;
    endfunction

    function automatic logic [127:0] point_gap(longint dx, longint dy);
        logic [127:0] sq;
        sq = 128'(dx * dx + dy * dy);
        return fixed_root(sq << (2 * FRAC_BITS), 128'd1);
    endfunction

    function automatic logic [127:0] point_to_seg(longint ax, longint ay, longint bx,
                                                  longint by, longint px, longint py);
        longint ux, uy, vx, vy, wx, wy, cr;
        logic [127:0] mag;
        ux = bx - ax; uy = by - ay; vx = px - ax; vy = py - ay;
        wx = px - bx; wy = py - by;
        if (ux == 0 && uy == 0)
            return point_gap(vx, vy);
        if (ux * vx + uy * vy < 0)
            return point_gap(vx, vy);
        if ((-ux) * wx + (-uy) * wy < 0)
            return point_gap(wx, wy);
        cr  = ux * vy - uy * vx;
        mag = 128'(cr < 0 ? -cr : cr);
        return fixed_root((mag * mag) << (2 * FRAC_BITS), 128'(ux * ux + uy * uy));
    endfunction

    // side of c against the ray a->b; collinear points get +-2 or 0 (on the segment)
    function automatic int side_of(longint ax, longint ay, longint bx, longint by,
                                   longint cx, longint cy);
        longint ux, uy, vx, vy, im, re;
        ux = bx - ax; uy = by - ay; vx = cx - ax; vy = cy - ay;
        im = uy * vx - ux * vy;
        re = ux * vx + uy * vy;
        if (im > 0) return 1;
        if (im < 0) return -1;
        if (re < 0) return 2;
        if (ux * ux + uy * uy < vx * vx + vy * vy) return -2;
        return 0;
    endfunction

    function automatic seg_result_t predict_distance(seg_item_t p);
        longint ax, ay, bx, by, cx, cy, dx, dy;
        logic [127:0] best, t;
        seg_result_t r;
        ax = p.first_start_x;  ay = p.first_start_y;
        bx = p.first_end_x;    by = p.first_end_y;
        cx = p.second_start_x; cy = p.second_start_y;
        dx = p.second_end_x;   dy = p.second_end_y;
        if (side_of(bx, by, ax, ay, cx, cy) * side_of(bx, by, ax, ay, dx, dy) <= 0 &&
            side_of(dx, dy, cx, cy, ax, ay) * side_of(dx, dy, cx, cy, bx, by) <= 0)
        begin
            r.distance_fixed = '0;
            r.segments_meet  = 1'b1;
            return r;
        end
        best = point_to_seg(ax, ay, bx, by, cx, cy);
        t = point_to_seg(ax, ay, bx, by, dx, dy);
        if (t < best) best = t;
        t = point_to_seg(cx, cy, dx, dy, ax, ay);
        if (t < best) best = t;
        t = point_to_seg(cx, cy, dx, dy, bx, by);
        if (t < best) best = t;
        r.distance_fixed = best[OUT_W-1:0];
        r.segments_meet  = 1'b0;
        return r;
    endfunction

    function automatic seg_item_t mk_pair(int ax, int ay, int bx, int by,
                                          int cx, int cy, int dx, int dy);
        seg_item_t p;
        p.first_start_x  = 16'(ax); p.first_start_y  = 16'(ay);
        p.first_end_x    = 16'(bx); p.first_end_y    = 16'(by);
        p.second_start_x = 16'(cx); p.second_start_y = 16'(cy);
        p.second_end_x   = 16'(dx); p.second_end_y   = 16'(dy);
        return p;
    endfunction

    function automatic seg_result_t mk_result(longint d, bit m);
        seg_result_t r;
        r.distance_fixed = OUT_W'(d);
        r.segments_meet  = m;
        return r;
    endfunction

    function automatic int pick_extreme();
        case ($urandom_range(0, 4))
            0: return -32768;
            1: return 32767;
            2: return 0;
            3: return -1;
            default: return 1;
        endcase
    endfunction

    function automatic seg_item_t random_pair();
        int c[8];
        int bx, by, sx, sy;
        int mode;
        mode = $urandom_range(0, 9);
        bx = $urandom_range(0, 65535) - 32768;
        by = $urandom_range(0, 65535) - 32768;
        sx = $urandom_range(0, 40) - 20;
        sy = $urandom_range(0, 40) - 20;
        for (int i = 0; i < 8; i++)
        begin
            case (mode)
                0, 1, 2: c[i] = $urandom_range(0, 65535);
                3, 4, 5: c[i] = ((i % 2) ? by : bx) + $urandom_range(0, 16) - 8;
                6:       c[i] = pick_extreme();
                // all four points on one line through the base point
                7:       c[i] = ((i % 2) ? by + sy * ($urandom_range(0, 8) - 4)
                                         : bx + sx * ($urandom_range(0, 8) - 4));
                default: c[i] = ((i % 2) ? by : bx) + $urandom_range(0, 4000) - 2000;
            endcase
        end
        if (mode == 7)
        begin
            // keep the multiplier shared per point so the line really holds
            for (int i = 0; i < 8; i += 2)
            begin
                int k;
                k = $urandom_range(0, 8) - 4;
                c[i] = bx + sx * k;
                c[i+1] = by + sy * k;
            end
        end
        // zero-length segments now and then
        if ($urandom_range(0, 9) == 0) begin c[2] = c[0]; c[3] = c[1]; end
        if ($urandom_range(0, 9) == 0) begin c[6] = c[4]; c[7] = c[5]; end
        return mk_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
    endfunction

    task automatic send_pair(input seg_item_t p, input bit typed, input seg_result_t want);
        int gap;
        if (burst_mode)
            gap = 0;
        else
            gap = $urandom_range(0, 17);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= p;
        do
            @(posedge clk);
        while (busy);
        pending_dist.push_back(typed ? want : predict_distance(p));
        n_sent++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            seg_result_t exp_r;
            if (pending_dist.size() == 0)
                report_mismatch("result with nothing expected");
            else
            begin
                exp_r = pending_dist.pop_front();
                n_checked++;
                if (result.segments_meet)
                    n_meet++;
                if (result.distance_fixed !== exp_r.distance_fixed)
                    report_mismatch($sformatf("distance_fixed got %0d want %0d",
                                              result.distance_fixed, exp_r.distance_fixed));
                if (result.segments_meet !== exp_r.segments_meet)
                    report_mismatch($sformatf("segments_meet got %0b want %0b",
                                              result.segments_meet, exp_r.segments_meet));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("segment_to_segment_distance_core_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        stim_row_t rows[$];
        n_errors = 0; n_sent = 0; n_checked = 0; n_meet = 0; cycle_count = 0;
        burst_mode = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        item  = '0;

        // crossing X
        rows.push_back('{mk_pair(-5, -5, 5, 5, -5, 5, 5, -5), 1, mk_result(0, 1)});
        // shared endpoint
        rows.push_back('{mk_pair(0, 0, 10, 0, 10, 0, 10, 7), 1, mk_result(0, 1)});
        // collinear overlap
        rows.push_back('{mk_pair(0, 0, 10, 0, 5, 0, 20, 0), 1, mk_result(0, 1)});
        // collinear, disjoint: gap of 3
        rows.push_back('{mk_pair(0, 0, 10, 0, 13, 0, 20, 0), 1, mk_result(3 << 16, 0)});
        // two points 3-4-5 apart
        rows.push_back('{mk_pair(0, 0, 0, 0, 3, 4, 3, 4), 1, mk_result(5 << 16, 0)});
        // same point twice
        rows.push_back('{mk_pair(7, 7, 7, 7, 7, 7, 7, 7), 1, mk_result(0, 1)});
        // parallel, 2 apart, overlapping projection
        rows.push_back('{mk_pair(0, 0, 10, 0, 2, 2, 8, 2), 1, mk_result(2 << 16, 0)});
        // point above segment interior
        rows.push_back('{mk_pair(-4, 0, 4, 0, 0, 6, 0, 6), 1, mk_result(6 << 16, 0)});
        // T-shape touching interior
        rows.push_back('{mk_pair(-4, 0, 4, 0, 0, 0, 0, 9), 1, mk_result(0, 1)});
        // extremes of the coordinate range
        rows.push_back('{mk_pair(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767),
                         0, mk_result(0, 0)});
        rows.push_back('{mk_pair(-32768, 32767, 32767, 32767, -32768, -32768, 32767, -32768),
                         0, mk_result(0, 0)});
        rows.push_back('{mk_pair(-32768, -32768, 32767, 32767, 32767, -32768, -32768, 32767),
                         1, mk_result(0, 1)});
        rows.push_back('{mk_pair(-1, -1, -1, -1, 0, 0, 0, 0), 0, mk_result(0, 0)});
        rows.push_back('{mk_pair(32767, 0, 32767, 1, -32768, 0, -32768, 1), 1,
                         mk_result(longint'(65535) << 16, 0)});
        // skewed, perpendicular foot on the other segment
        rows.push_back('{mk_pair(0, 0, 100, 37, 50, 90, 120, 200), 0, mk_result(0, 0)});

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_pair(rows[i].pair, rows[i].typed, rows[i].want);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i % 100 == 0)
                burst_mode = $urandom_range(0, 2) == 0;
            if (i == N_RANDOM / 2)
            begin
                // drain the pipe once before carrying on
                start <= 1'b0;
                while (pending_dist.size() != 0)
                    @(posedge clk);
            end
            send_pair(random_pair(), 1'b0, mk_result(0, 0));
        end
        start <= 1'b0;

        while (pending_dist.size() != 0)
            @(posedge clk);
        repeat (TOTAL_LAT + 10) @(posedge clk);

        $display("sent %0d segment pairs (%0d directed), checked %0d results, %0d meeting",
                 n_sent, rows.size(), n_checked, n_meet);
        $display("mix: full-range, clustered, collinear, degenerate and extreme coordinates");
        if (n_errors == 0)
            $display("segment_to_segment_distance_core_tb: done, clean");
        else
            $display("segment_to_segment_distance_core_tb: done, errors");
        $finish;
    end

endmodule

// ----- sim.f -----
design/ssd_pkg.sv
design/ssd_leg.sv
design/ssd_div.sv
design/ssd_sqrt.sv
design/segment_to_segment_distance_core.sv
design/ssd_checker.sv
dv/segment_to_segment_distance_core_tb.sv
